// ===== src/ulrb_pkg.sv =====
// Package of the serial receive line buffer.
// Holds ring sizes, byte codes and request codes; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ulrb_pkg;

  // Ring of bytes, a power of two; holds at most RING_DEPTH - 1 bytes.
  localparam int unsigned RING_DEPTH = 32;
  localparam int unsigned IDX_W = $clog2(RING_DEPTH);

  // A line read yields at most MAX_RESULTS transactions, the terminator included.
  localparam int unsigned MAX_RESULTS = 32;
  localparam int unsigned CNT_W = $clog2(MAX_RESULTS);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_RESULTS - 2);

  localparam logic [7:0] BYTE_NUL = 8'h00;
  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_CR = 8'h0D;

  typedef enum logic [1:0] {
    REQ_RX_BYTE   = 2'd0,
    REQ_READ_BYTE = 2'd1,
    REQ_READ_LINE = 2'd2
  } req_e;

endpackage

`default_nettype wire

// ===== src/ulrb_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
// Stands alone; read data updates only when a read is enabled.
`timescale 1ns / 1ps
`default_nettype none

module ulrb_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/uart_line_receive_buffer.sv =====
// Top level of the serial receive line buffer: sequencer, indices, line count
// and output register around one ring RAM. Depends on ulrb_pkg and ulrb_ram.
//
//  Channel   Dir  Handshake               Payload
//  s_axis    in   s_axis_tvalid/tready    tuser = req_type, tdata = rx_byte
//  m_axis    out  m_axis_tvalid/tready    tdata = data_byte, lines_pending;
//                                         tuser = data_valid; tlast = last_of_run
//
// A received byte, an empty byte read, a line read with no complete line and an
// unknown request are answered straight from idle. A byte read from a non-empty
// ring waits in BYTE_WAIT because the ring RAM has a registered read port. A line
// read issues the first RAM read, then emits the bytes one by one and finally the
// terminator. Reset clears the indices and the line count, so the ring starts
// empty; the RAM contents need no clearing. A stall on the output side holds
// the sequencer in place, with the pending RAM read data kept in the RAM's
// output register.
`timescale 1ns / 1ps
`default_nettype none

module uart_line_receive_buffer (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Request channel.
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [7:0]            s_axis_tdata_i,   // [7:0] rx_byte
  input  wire logic [1:0]            s_axis_tuser_i,   // [1:0] req_type
  // Result channel.
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output logic      [15:0]           m_axis_tdata_o,   // [7:0] data_byte, [15:8] lines_pending
  output logic                       m_axis_tuser_o,   // [0] data_valid
  output logic                       m_axis_tlast_o    // last_of_run
);

  import ulrb_pkg::*;

  // The sequencer waits in BYTE_WAIT or LINE_WAIT for data from the RAM and
  // in TERM to emit a line terminator.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BYTE_WAIT,
    ST_LINE_WAIT,
    ST_TERM
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] wr_idx_q, wr_idx_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic [7:0]       line_cnt_q, line_cnt_d;
  logic [CNT_W-1:0] n_q, n_d;

  // Output register.
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_byte_q, out_byte_d;
  logic             out_flag_q, out_flag_d;
  logic             out_last_q, out_last_d;
  logic [7:0]       out_lines_q, out_lines_d;

  logic             out_free;
  logic             out_load;
  logic             in_fire;
  logic [IDX_W-1:0] wr_next;
  logic [7:0]       rx_byte;
  req_e             req;

  // RAM port signals.
  logic             ram_we;
  logic             ram_re;
  logic [7:0]       ram_rdata;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign rx_byte         = s_axis_tdata_i;
  assign req             = req_e'(s_axis_tuser_i);
  assign wr_next         = wr_idx_q + IDX_W'(1);

  ulrb_ram #(
    .DATA_W(8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wr_next),
    .wdata_i(rx_byte),
    .re_i   (ram_re),
    .raddr_i(rd_idx_q + IDX_W'(1)),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    wr_idx_d   = wr_idx_q;
    rd_idx_d   = rd_idx_q;
    line_cnt_d = line_cnt_q;
    n_d        = n_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    out_load   = 1'b0;
    out_byte_d = BYTE_NUL;
    out_flag_d = 1'b0;
    out_last_d = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (req)
            REQ_RX_BYTE: begin
              // A byte arriving at a full ring flushes the ring and is lost.
              if (wr_next == rd_idx_q) begin
                wr_idx_d = rd_idx_q;
              end else if (rx_byte != BYTE_NUL && rx_byte != BYTE_LF) begin
                if (rx_byte == BYTE_CR) begin
                  line_cnt_d = line_cnt_q + 8'd1;
                end
                wr_idx_d = wr_next;
                ram_we   = 1'b1;
              end
              out_load = 1'b1;
            end
            REQ_READ_BYTE: begin
              if (rd_idx_q == wr_idx_q) begin
                out_load = 1'b1;
              end else begin
                ram_re   = 1'b1;
                rd_idx_d = rd_idx_q + IDX_W'(1);
                state_d  = ST_BYTE_WAIT;
              end
            end
            REQ_READ_LINE: begin
              if (line_cnt_q == 8'd0) begin
                out_load = 1'b1;
              end else if (rd_idx_q == wr_idx_q) begin
                state_d = ST_TERM;
              end else begin
                ram_re   = 1'b1;
                rd_idx_d = rd_idx_q + IDX_W'(1);
                n_d      = '0;
                state_d  = ST_LINE_WAIT;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_BYTE_WAIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_byte_d = ram_rdata;
          out_flag_d = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_LINE_WAIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_flag_d = 1'b1;
          if (ram_rdata == BYTE_CR) begin
            // The carriage return is consumed and the terminator takes its place.
            line_cnt_d = line_cnt_q - 8'd1;
            state_d    = ST_IDLE;
          end else begin
            out_byte_d = ram_rdata;
            out_last_d = 1'b0;
            n_d        = n_q + CNT_W'(1);
            if (n_q != LAST_CNT && rd_idx_q != wr_idx_q) begin
              ram_re   = 1'b1;
              rd_idx_d = rd_idx_q + IDX_W'(1);
            end else begin
              state_d = ST_TERM;
            end
          end
        end
      end
      ST_TERM: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_flag_d = 1'b1;
          line_cnt_d = line_cnt_q - 8'd1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    out_lines_d = line_cnt_d;
    out_valid_d = (out_valid_q && !m_axis_tready_i) || out_load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wr_idx_q    <= '0;
      rd_idx_q    <= '0;
      line_cnt_q  <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_flag_q  <= 1'b0;
      out_last_q  <= 1'b0;
      out_lines_q <= '0;
    end else begin
      state_q     <= state_d;
      wr_idx_q    <= wr_idx_d;
      rd_idx_q    <= rd_idx_d;
      line_cnt_q  <= line_cnt_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
      if (out_load) begin
        out_byte_q  <= out_byte_d;
        out_flag_q  <= out_flag_d;
        out_last_q  <= out_last_d;
        out_lines_q <= out_lines_d;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_lines_q, out_byte_q};
  assign m_axis_tuser_o  = out_flag_q;
  assign m_axis_tlast_o  = out_last_q;

  // The ring is written only while a request is being taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_IDLE))
    else $error("ring write outside idle");

  // A RAM read is issued only for a non-empty ring.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_re |-> (rd_idx_q != wr_idx_q))
    else $error("ring read from an empty ring");

  // A new result never overwrites one that has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("output register overwritten");

  // A line read never emits more bytes than one run allows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LINE_WAIT) |-> (n_q <= LAST_CNT))
    else $error("line run exceeds its result limit");

endmodule

`default_nettype wire
